FILE: design/rilbp_pkg.sv
// Shared types, constants and functions of the rotation-invariant 3x3 LBP block.
`default_nettype none
package rilbp_pkg;

  localparam int PIX_W = 8;
  localparam int MAX_WIDTH = 128;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int FW_W = 8;
  localparam int FH_W = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int WIN_N = 9;
  localparam int RING_N = 8;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(128);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(128);
  localparam logic [FW_W-1:0] FW_MIN = FW_W'(3);
  localparam logic [FW_W-1:0] FW_MAX = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] FH_MIN = FH_W'(3);
  localparam logic [FH_W-1:0] FH_MAX = FH_W'(MAX_HEIGHT);

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;
  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    logic row_last;
    logic frame_last;
  } tag_t;

  typedef logic [3:0] ring_idx_t;
  localparam ring_idx_t RING [RING_N] = '{
    4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3
  };

  function automatic logic [RING_N-1:0] threshold_bits(input win_t win);
    logic [RING_N-1:0] bits;
    bits = '0;
    for (int k = 0; k < RING_N; k++) begin
      bits[k] = (win[RING[k]] >= win[4]);
    end
    return bits;
  endfunction

  function automatic logic [RING_N-1:0] min_rotation(input logic [RING_N-1:0] b);
    logic [RING_N-1:0] best;
    logic [RING_N-1:0] rot;
    best = '1;
    for (int r = 0; r < RING_N; r++) begin
      rot = (b >> r) | (b << (RING_N - r));
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

endpackage
`default_nettype wire

FILE: design/rilbp_line_mem.sv
// Line store memory: one entry per column holds the two previous rows.
`default_nettype none
module rilbp_line_mem (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire rilbp_pkg::col_t      rd_addr,
  output rilbp_pkg::line_pair_t     rd_data,
  input  wire logic                 wr_en,
  input  wire rilbp_pkg::col_t      wr_addr,
  input  wire rilbp_pkg::line_pair_t wr_data
);
  import rilbp_pkg::*;

  line_pair_t mem [MAX_WIDTH];
  line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/rilbp_code.sv
// Threshold and rotation-minimum stages with the output register.
`default_nettype none
module rilbp_code (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              win_valid,
  input  wire rilbp_pkg::win_t   win,
  input  wire rilbp_pkg::tag_t   win_tag,
  output logic                   win_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_lbp_code,
  output logic                   out_row_last,
  output logic                   out_frame_last
);
  import rilbp_pkg::*;

  logic                bits_valid_r;
  logic                bits_valid_nxt;
  logic [RING_N-1:0]   bits_r;
  tag_t                bits_tag_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [RING_N-1:0]   code_r;
  tag_t                out_tag_r;
  logic                out_free;
  logic                bits_take;
  logic                win_take;

  assign out_free  = !out_valid_r || !out_stall;
  assign bits_take = bits_valid_r && out_free;
  assign win_free  = !bits_valid_r || out_free;
  assign win_take  = win_valid && win_free;

  always_comb begin
    bits_valid_nxt = bits_valid_r;
    if (win_take) begin
      bits_valid_nxt = 1'b1;
    end else if (bits_take) begin
      bits_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (bits_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bits_valid_r <= bits_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_take) begin
      bits_r     <= threshold_bits(win);
      bits_tag_r <= win_tag;
    end
    if (bits_take) begin
      code_r    <= min_rotation(bits_r);
      out_tag_r <= bits_tag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lbp_code   = code_r;
  assign out_row_last   = out_tag_r.row_last;
  assign out_frame_last = out_tag_r.frame_last;

endmodule
`default_nettype wire

FILE: design/rotation_invariant_lbp_3x3.sv
// Top level of the rotation-invariant 3x3 local binary pattern block.
//
// The block takes one pixel per clock in raster order and sustains one transfer per clock on
// both channels while the receiver does not stall the output. Each pixel costs one read of
// the line store at its column and, when it leaves the read stage, one write of the same entry.
// A result passes the read stage, window register and threshold register to the output
// register; border pixels give no result. A register write restarts the frame at its first pixel.
`default_nettype none
module rotation_invariant_lbp_3x3 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_pixel,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_lbp_code,
  output logic                               out_row_last,
  output logic                               out_frame_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rilbp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rilbp_pkg::DATA_W-1:0]  pwdata,
  output logic [rilbp_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);
  import rilbp_pkg::*;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic             cfg_wr;

  col_t             col_r;
  col_t             col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic             col_end;
  logic             row_end;
  logic             in_take;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  col_t             s1_col_r;
  pix_t             s1_pix_r;
  logic             s1_emit_r;
  tag_t             s1_tag_r;
  logic             s1_go;

  logic             s2_valid_r;
  logic             s2_valid_nxt;
  logic             s2_free;
  logic             code_free;
  tag_t             s2_tag_r;
  win_t             win_r;
  win_t             win_nxt;

  line_pair_t       line_rd;
  line_pair_t       line_wr;

  // Configuration registers and saturation.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    eff_w = frame_width_r;
    if (frame_width_r < FW_MIN) begin
      eff_w = FW_MIN;
    end else if (frame_width_r > FW_MAX) begin
      eff_w = FW_MAX;
    end
    eff_h = frame_height_r;
    if (frame_height_r < FH_MIN) begin
      eff_h = FH_MIN;
    end else if (frame_height_r > FH_MAX) begin
      eff_h = FH_MAX;
    end
  end

  // Column and row position of the next pixel.
  assign s2_free  = !s2_valid_r || code_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  assign col_end = (FW_W'(col_r) == eff_w - FW_W'(1));
  assign row_end = (FH_W'(row_r) == eff_h - FH_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_take) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store read stage.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r            <= col_r;
      s1_pix_r            <= in_pixel;
      s1_emit_r           <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_tag_r.row_last   <= col_end;
      s1_tag_r.frame_last <= col_end && row_end;
    end
  end

  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = s1_pix_r;

  rilbp_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (line_wr)
  );

  // Window shift stage.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]     = win_r[k*3 + 1];
      win_nxt[k*3 + 1] = win_r[k*3 + 2];
    end
    win_nxt[2] = line_rd.upper;
    win_nxt[5] = line_rd.middle;
    win_nxt[8] = s1_pix_r;
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s1_go) begin
      s2_valid_nxt = s1_emit_r;
    end else if (code_free) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r    <= win_nxt;
      s2_tag_r <= s1_tag_r;
    end
  end

  rilbp_code u_code (
    .clk            (clk),
    .rst_n          (rst_n),
    .win_valid      (s2_valid_r),
    .win            (win_r),
    .win_tag        (s2_tag_r),
    .win_free       (code_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lbp_code   (out_lbp_code),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the rotation-invariant 3x3 LBP block with a scoreboard class.
module tb;

  localparam int TOTAL_ITEMS = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_PHASE_ITEMS = 400;
  localparam int RING_POS [8] = '{0, 1, 2, 5, 8, 7, 6, 3};
  localparam logic [rilbp_pkg::ADDR_W-1:0] ADDR_FRAME_WIDTH =
    rilbp_pkg::ADDR_W'(4 * rilbp_pkg::REG_FRAME_WIDTH);
  localparam logic [rilbp_pkg::ADDR_W-1:0] ADDR_FRAME_HEIGHT =
    rilbp_pkg::ADDR_W'(4 * rilbp_pkg::REG_FRAME_HEIGHT);

  typedef enum int {PIX_RANDOM, PIX_NEAR_BASE, PIX_EXTREME} pixel_mode_t;

  typedef struct packed {
    logic [7:0] code;
    logic       row_last;
    logic       frame_last;
  } lbp_result_t;

  class lbp_scoreboard;
    logic [7:0] upper_row [rilbp_pkg::MAX_WIDTH];
    logic [7:0] middle_row [rilbp_pkg::MAX_WIDTH];
    logic [7:0] win [9];
    int unsigned col;
    int unsigned row;
    logic [rilbp_pkg::FW_W-1:0] width_reg;
    logic [rilbp_pkg::FH_W-1:0] height_reg;
    lbp_result_t expected_q [$];
    int failures;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      width_reg = rilbp_pkg::FW_RESET;
      height_reg = rilbp_pkg::FH_RESET;
      failures = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > rilbp_pkg::MAX_WIDTH) w = rilbp_pkg::MAX_WIDTH;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > rilbp_pkg::MAX_HEIGHT) h = rilbp_pkg::MAX_HEIGHT;
      return h;
    endfunction

    function void write_width(logic [rilbp_pkg::FW_W-1:0] v);
      width_reg = v;
      col = 0;
      row = 0;
    endfunction

    function void write_height(logic [rilbp_pkg::FH_W-1:0] v);
      height_reg = v;
      col = 0;
      row = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] rot_min(logic [7:0] b);
      logic [7:0] best;
      logic [7:0] rot;
      best = 8'hff;
      for (int s = 0; s < 8; s++) begin
        rot = 8'({b, b} >> s);
        if (rot < best) best = rot;
      end
      return best;
    endfunction

    function void note_pixel(logic [7:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [7:0] up;
      logic [7:0] mid;
      logic [7:0] bits;
      lbp_result_t res;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      up = upper_row[c];
      mid = middle_row[c];
      for (int k = 0; k < 3; k++) begin
        win[3*k] = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      upper_row[c] = mid;
      middle_row[c] = px;
      if (r >= 2 && c >= 2) begin
        bits = '0;
        for (int k = 0; k < 8; k++) bits[k] = (win[RING_POS[k]] >= win[4]);
        res.code = rot_min(bits);
        res.row_last = (c == w - 1);
        res.frame_last = (c == w - 1) && (r == h - 1);
        expected_q.push_back(res);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void check_result(logic [7:0] code, logic rl, logic fl);
      lbp_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: code=%0d row_last=%0b frame_last=%0b", code, rl, fl);
      end else begin
        want = expected_q.pop_front();
        if (want.code !== code || want.row_last !== rl || want.frame_last !== fl) begin
          failures++;
          if (failures <= 10)
            $display("Mismatch: expected code=%0d row_last=%0b frame_last=%0b, got %0d %0b %0b",
                     want.code, want.row_last, want.frame_last, code, rl, fl);
        end
      end
    endfunction

    function void check_register(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("Register %s read back: expected %0d, got %0d", name, want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_pixel = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rilbp_pkg::ADDR_W-1:0] paddr = '0;
  logic [rilbp_pkg::DATA_W-1:0] pwdata = '0;
  wire in_stall;
  wire out_valid;
  wire [7:0] out_lbp_code;
  wire out_row_last;
  wire out_frame_last;
  wire [rilbp_pkg::DATA_W-1:0] prdata;
  wire pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  lbp_scoreboard sb;

  rotation_invariant_lbp_3x3 u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel(in_pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_lbp_code(out_lbp_code),
    .out_row_last(out_row_last),
    .out_frame_last(out_frame_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_pixel);
      if (out_valid && !out_stall) sb.check_result(out_lbp_code, out_row_last, out_frame_last);
    end
  end

  task automatic send_pixel(input logic [7:0] p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rilbp_pkg::ADDR_W-1:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read(input logic [rilbp_pkg::ADDR_W-1:0] a, output logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input bit wr_w, input logic [7:0] w, input bit wr_h,
                           input logic [12:0] h);
    logic [31:0] rd;
    if (wr_w) begin
      cfg_write(ADDR_FRAME_WIDTH, 32'(w));
      sb.write_width(w);
    end
    if (wr_h) begin
      cfg_write(ADDR_FRAME_HEIGHT, 32'(h));
      sb.write_height(h);
    end
    cfg_read(ADDR_FRAME_WIDTH, rd);
    sb.check_register("frame_width", 32'(sb.width_reg), rd);
    cfg_read(ADDR_FRAME_HEIGHT, rd);
    sb.check_register("frame_height", 32'(sb.height_reg), rd);
  endtask

  function automatic logic [7:0] gen_pixel(input pixel_mode_t mode, input logic [7:0] base);
    case (mode)
      PIX_NEAR_BASE: return 8'(base + $urandom_range(0, 2) - 1);
      PIX_EXTREME:   return $urandom_range(1) ? 8'hff : 8'h00;
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] directed [27] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd128, 8'd127, 8'd129, 8'd127, 8'd128, 8'd128, 8'd0, 8'd255, 8'd127
    };
    int sent;
    int kind;
    int frames;
    int extra;
    int count;
    bit wr_w;
    bit wr_h;
    logic [7:0] w_raw;
    logic [12:0] h_raw;
    logic [7:0] base;
    pixel_mode_t mode;

    sb = new();
    send_idle_pct = 27;
    recv_idle_pct = 61;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three 3x3 frames: flat, bright corner and bright center, and values around the center.
    set_frame(1'b1, 8'd3, 1'b1, 13'd3);
    foreach (directed[i]) send_pixel(directed[i]);
    sent = 27;

    // The receiver holds off while pixels keep coming; halfway the sender waits for all results.
    drain_results();
    set_frame(1'b1, 8'd16, 1'b1, 13'd8);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (i == 64) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_pixel(8'($urandom_range(255)));
    end
    sent += 128;

    while (sent < TOTAL_ITEMS) begin
      if (sent < 600) begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end else if (sent < 1150) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = $urandom_range(15);
      wr_w = 1'b1;
      wr_h = 1'b1;
      case ($urandom_range(5))
        0: wr_w = 1'b0;
        1: wr_h = 1'b0;
        default: ;
      endcase
      case (kind)
        0: begin
          w_raw = 8'($urandom_range(2));
          h_raw = 13'($urandom_range(2));
          frames = 2;
          extra = 0;
        end
        1: begin
          case ($urandom_range(2))
            0: w_raw = 8'd128;
            1: w_raw = 8'd255;
            default: w_raw = 8'($urandom_range(129, 254));
          endcase
          h_raw = 13'd3;
          frames = 1;
          extra = 0;
        end
        2: begin
          w_raw = 8'($urandom_range(3, 6));
          case ($urandom_range(2))
            0: h_raw = 13'd4096;
            1: h_raw = 13'd8191;
            default: h_raw = 13'($urandom_range(4097, 8190));
          endcase
          frames = 0;
          extra = $urandom_range(20, 60);
        end
        default: begin
          w_raw = 8'($urandom_range(3, 12));
          h_raw = 13'($urandom_range(3, 8));
          frames = $urandom_range(1, 3);
          extra = $urandom_range(1) ? $urandom_range(0, 20) : 0;
        end
      endcase
      drain_results();
      set_frame(wr_w, w_raw, wr_h, h_raw);
      count = frames * int'(sb.eff_width() * sb.eff_height()) + extra;
      if (count > MAX_PHASE_ITEMS) count = MAX_PHASE_ITEMS;
      if (count == 0) count = 1;
      mode = pixel_mode_t'($urandom_range(2));
      base = 8'($urandom_range(255));
      for (int i = 0; i < count; i++) send_pixel(gen_pixel(mode, base));
      in_valid <= 1'b0;
      @(posedge clk);
      sent += count;
    end

    drain_results();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
